FILE: rtl/core/rtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request tracking table package
// Sizes, operation and status codes, and the words that travel between the
// top level and the row of table cells.
// ----------------------------------------------------------------------------
package rtt_pkg;

   localparam int ENTRIES   = 32;
   localparam int KEY_BYTES = 8;

   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);
   localparam logic [62:0] MAX_TIME = {63{1'b1}};

   // operation codes
   localparam logic [2:0] KIND_CREATE      = 3'd0;
   localparam logic [2:0] KIND_SET_STATUS  = 3'd1;
   localparam logic [2:0] KIND_CANCEL      = 3'd2;
   localparam logic [2:0] KIND_SET_TIMEOUT = 3'd3;
   localparam logic [2:0] KIND_QUERY       = 3'd4;

   // status codes
   localparam logic [2:0] STATUS_CREATED   = 3'd0;
   localparam logic [2:0] STATUS_RUNNING   = 3'd1;
   localparam logic [2:0] STATUS_COMPLETED = 3'd2;
   localparam logic [2:0] STATUS_FAILED    = 3'd3;
   localparam logic [2:0] STATUS_CANCELLED = 3'd4;
   localparam logic [2:0] STATUS_TIMED_OUT = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_DONE
   } rtt_state_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [63:0]        request_key;
      logic signed [31:0] generation;
      logic [2:0]         new_status;
      logic [62:0]        now_ms;
      logic signed [63:0] timeout_value;
   } rtt_req_type;

   typedef struct packed {
      logic        ok;
      logic [62:0] deadline;
      logic [5:0]  entry_count;
   } rtt_rsp_type;

   // word handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic [2:0]         kind;
      logic [63:0]        request_key;
      logic signed [31:0] generation;
      logic [2:0]         new_status;
      logic [62:0]        now_ms;
      logic signed [63:0] timeout_value;
      logic               hit;
      logic               ok;
      logic               grow;
      logic [62:0]        created;
      logic [62:0]        tmo;
   } rtt_word_type;

   function automatic logic is_terminal(input logic [2:0] status);
      is_terminal = (status >= STATUS_COMPLETED) && (status <= STATUS_TIMED_OUT);
   endfunction

endpackage

FILE: rtl/core/rtt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request tracking table cell
// Holds one table entry. Compares the passing word's key with its own,
// applies the operation on a hit or takes a new entry on create, and hands
// the word on to the next cell through its output register.
// ----------------------------------------------------------------------------
module rtt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rtt_pkg::IDX_W-1:0]   cell_index,
   input  logic [rtt_pkg::COUNT_W-1:0] used_count,
   input  rtt_pkg::rtt_word_type       word_in,
   output rtt_pkg::rtt_word_type       word_out
);
   import rtt_pkg::*;

   logic [63:0]        key_ff,       key_in;
   logic signed [31:0] gen_ff,       gen_in;
   logic [2:0]         status_ff,    status_in;
   logic [62:0]        created_ff,   created_in;
   logic [62:0]        started_ff,   started_in;
   logic [62:0]        completed_ff, completed_in;
   logic [62:0]        timeout_ff,   timeout_in;
   logic               cancelled_ff, cancelled_in;
   rtt_word_type       word_ff,      word_in_nx;

   logic live;
   logic match;
   logic append;

   // compare, then update the entry and the passing word
   always_comb begin
      key_in       = key_ff;
      gen_in       = gen_ff;
      status_in    = status_ff;
      created_in   = created_ff;
      started_in   = started_ff;
      completed_in = completed_ff;
      timeout_in   = timeout_ff;
      cancelled_in = cancelled_ff;
      word_in_nx   = word_in;

      live   = word_in.valid && !word_in.hit && (COUNT_W'(cell_index) < used_count);
      match  = live && (key_ff == word_in.request_key);
      append = word_in.valid && !word_in.hit && (word_in.kind == KIND_CREATE) &&
               (COUNT_W'(cell_index) == used_count);

      if (match) begin
         word_in_nx.hit = 1'b1;
         case (word_in.kind)
            KIND_SET_STATUS: begin
               if ((word_in.new_status <= STATUS_TIMED_OUT) &&
                   (!is_terminal(status_ff) || (word_in.new_status == status_ff))) begin
                  status_in = word_in.new_status;
                  if ((word_in.new_status == STATUS_RUNNING) && (started_ff == '0))
                     started_in = word_in.now_ms;
                  if (is_terminal(word_in.new_status) && (completed_ff == '0))
                     completed_in = word_in.now_ms;
                  word_in_nx.ok = 1'b1;
               end
            end
            KIND_CANCEL: begin
               if (!is_terminal(status_ff)) begin
                  cancelled_in = 1'b1;
                  status_in    = STATUS_CANCELLED;
                  if (completed_ff == '0)
                     completed_in = word_in.now_ms;
               end
               word_in_nx.ok = 1'b1;
            end
            KIND_SET_TIMEOUT: begin
               if (!word_in.timeout_value[63]) begin
                  timeout_in    = word_in.timeout_value[62:0];
                  word_in_nx.ok = 1'b1;
               end
            end
            KIND_QUERY: begin
               word_in_nx.ok      = 1'b1;
               word_in_nx.created = created_ff;
               word_in_nx.tmo     = timeout_ff;
            end
            default: begin
               word_in_nx.ok = 1'b0;
            end
         endcase
      end else if (append) begin
         key_in          = word_in.request_key;
         gen_in          = word_in.generation;
         status_in       = STATUS_CREATED;
         created_in      = word_in.now_ms;
         started_in      = '0;
         completed_in    = '0;
         timeout_in      = '0;
         cancelled_in    = 1'b0;
         word_in_nx.hit  = 1'b1;
         word_in_nx.ok   = 1'b1;
         word_in_nx.grow = 1'b1;
      end
   end

   // hold the entry
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      gen_ff       <= gen_in;
      status_ff    <= status_in;
      created_ff   <= created_in;
      started_ff   <= started_in;
      completed_ff <= completed_in;
      timeout_ff   <= timeout_in;
      cancelled_ff <= cancelled_in;
   end

   // advance the word
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff <= word_in_nx;
      end
   end

   assign word_out = word_ff;

endmodule

FILE: rtl/core/request_tracking_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request tracking table unit
// Keeps up to ENTRIES outstanding requests in a row of cells, one entry per
// cell. An accepted request word walks the row one cell per cycle; when it
// leaves the row, the tail register takes its result with the added-up
// deadline and the settled entry count, and the result then moves into the
// output register as soon as the output is free.
// One word is in the table at a time; the request side stalls from the
// accepting edge until its result has moved into the output register, and
// a result waiting on the output does not hold up the next request.
// ----------------------------------------------------------------------------
module request_tracking_table_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rtt_pkg::rtt_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rtt_pkg::rtt_rsp_type rsp_word
);
   import rtt_pkg::*;

   rtt_state_type         state_ff,     state_in;
   logic [COUNT_W-1:0]    used_ff,      used_in;
   rtt_rsp_type           tail_ff,      tail_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rtt_rsp_type           rsp_word_ff,  rsp_word_in;

   rtt_word_type          chain_word [0:ENTRIES];
   logic [ENTRIES-1:0]    word_valid;
   rtt_word_type          exit_word;
   logic [63:0]           sum;
   logic [62:0]           deadline;

   // build the word that enters the row
   always_comb begin
      chain_word[0]               = '0;
      chain_word[0].valid         = req_valid && (state_ff == ST_IDLE);
      chain_word[0].kind          = req_word.kind;
      chain_word[0].request_key   = req_word.request_key & KEY_MASK;
      chain_word[0].generation    = req_word.generation;
      chain_word[0].new_status    = req_word.new_status;
      chain_word[0].now_ms        = req_word.now_ms;
      chain_word[0].timeout_value = req_word.timeout_value;
   end

   // row of cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      rtt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .used_count (used_ff),
         .word_in    (chain_word[i]),
         .word_out   (chain_word[i+1])
      );
      assign word_valid[i] = chain_word[i+1].valid;
   end

   assign exit_word = chain_word[ENTRIES];

   // saturating deadline from the row's exit word
   always_comb begin
      sum = {1'b0, exit_word.created} + {1'b0, exit_word.tmo};
      if (exit_word.tmo == '0) begin
         deadline = '0;
      end else if (sum[63]) begin
         deadline = MAX_TIME;
      end else begin
         deadline = sum[62:0];
      end
   end

   // sequence one word at a time
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      tail_in      = tail_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;

      // drop a taken result
      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (exit_word.valid) begin
               used_in             = used_ff + COUNT_W'(exit_word.grow);
               tail_in.ok          = exit_word.ok;
               tail_in.deadline    = deadline;
               tail_in.entry_count = 6'(used_in);
               state_in            = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = tail_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // the table never holds more entries than it has cells
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= COUNT_W'(ENTRIES))
      else $error("entry count beyond table size");

   // only one word walks the row
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      $countones(word_valid) <= 1)
      else $error("more than one word in the row");

   // a word leaves the row only while the sequencer waits for it
   a_exit_busy: assert property (@(posedge clock) disable iff (reset)
      exit_word.valid |-> (state_ff == ST_BUSY))
      else $error("word left the row outside busy state");

   // the entry count moves only when a word leaves the row
   a_used_hold: assert property (@(posedge clock) disable iff (reset)
      !exit_word.valid |=> $stable(used_ff))
      else $error("entry count changed without a finished word");

endmodule
